>>> hw/rtl/tkmp_pkg.sv
// ----------------------------------------------------------------------------
// tkmp_pkg
// shared types and constants of the per-channel top-k max pool
// ----------------------------------------------------------------------------
`default_nettype none

package tkmp_pkg;

    localparam int VALUE_W  = 32;   // signed q16.16
    localparam int POS_W    = 13;   // stored position, -1 when empty
    localparam int IN_POS_W = 12;   // position as it arrives
    localparam int CH_W     = 6;
    localparam int RANK_W   = 3;
    localparam int KEEP_W   = 4;

    localparam logic [VALUE_W-1:0] EMPTY_VALUE    = 32'h8000_0000;
    localparam logic [POS_W-1:0]   EMPTY_POSITION = 13'h1FFF;

    // one kept sample of a row
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t EMPTY_ENTRY = '{value: EMPTY_VALUE, position: EMPTY_POSITION};

    // classified sample queued between front and back
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [CH_W-1:0]           channel;
        logic [POS_W-1:0]          position;
        logic                      clear;
        logic                      insert;
        logic                      emit;
    } item_t;

    // one ranked result word
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
        logic [RANK_W-1:0]         rank;
        logic [CH_W-1:0]           channel;
        logic                      last;
    } out_word_t;

endpackage

`default_nettype wire

>>> hw/rtl/tkmp_ram.sv
// ----------------------------------------------------------------------------
// tkmp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tkmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [WIDTH-1:0]      wdata,
    input  wire logic                  re,
    input  wire logic [AW-1:0]         raddr,
    output logic      [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tkmp_front.sv
// ----------------------------------------------------------------------------
// tkmp_front
// accepts samples, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module tkmp_front #(
    parameter int CHANNELS       = 64,
    parameter int POOL_POSITIONS = 4096
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             enable,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [tkmp_pkg::VALUE_W-1:0]     sample_value,
    input  wire logic [tkmp_pkg::CH_W-1:0]        channel,
    input  wire logic [tkmp_pkg::IN_POS_W-1:0]    position,
    input  wire logic                             first_of_object,
    input  wire logic                             last_of_object,
    output logic                                  q_valid,
    input  wire logic                             q_ready,
    output tkmp_pkg::item_t                       q_item
);

    tkmp_pkg::item_t in_item;
    tkmp_pkg::item_t fifo_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            channel_ok;
    logic            push;
    logic            pop;

    // out-of-range channel: word is taken and dropped
    assign channel_ok = 32'(channel) < CHANNELS;

    always_comb
    begin
        in_item.value    = $signed(sample_value);
        in_item.channel  = channel;
        in_item.position = {1'b0, position};
        in_item.clear    = first_of_object;
        in_item.insert   = 32'(position) < POOL_POSITIONS;
        in_item.emit     = last_of_object;
    end

    assign s_ready = enable && (count_reg != 2'd2);
    assign push    = s_valid && s_ready && channel_ok;
    assign q_valid = count_reg != 2'd0;
    assign pop     = q_valid && q_ready;
    assign q_item  = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tkmp_back.sv
// ----------------------------------------------------------------------------
// tkmp_back
// row read-modify-write per sample and ranked emission of a row
// ----------------------------------------------------------------------------
`default_nettype none

module tkmp_back #(
    parameter int MAX_KEEP = 8,
    parameter int CHANNELS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [tkmp_pkg::KEEP_W-1:0]   keep_count,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire tkmp_pkg::item_t               q_item,
    output logic                               clear_done,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output tkmp_pkg::out_word_t                out_word
);

    localparam int IW    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int KW    = $clog2(MAX_KEEP + 1);
    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ROW_W = MAX_KEEP * tkmp_pkg::ENTRY_W;

    typedef tkmp_pkg::entry_t [MAX_KEEP-1:0] row_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MODIFY,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    tkmp_pkg::item_t     cur_reg, cur_next;
    row_t                row_reg, row_next;
    logic [IW-1:0]       emit_idx_reg, emit_idx_next;
    logic                out_valid_reg, out_valid_next;
    tkmp_pkg::out_word_t out_word_reg, out_word_next;

    logic [KW-1:0]       keep_eff;
    logic [KW-1:0]       keep_last;
    logic                q_pop;
    logic                out_free;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;
    logic [ROW_W-1:0]    ram_rdata;
    row_t                empty_row;
    row_t                base_row;
    row_t                new_row;
    logic [MAX_KEEP-1:0] ge;
    logic                found;

    // zero keeps one, above the row size saturates
    always_comb
    begin
        if (keep_count == '0)
        begin
            keep_eff = KW'(1);
        end
        else if (32'(keep_count) > MAX_KEEP)
        begin
            keep_eff = KW'(MAX_KEEP);
        end
        else
        begin
            keep_eff = KW'(keep_count);
        end
        keep_last = keep_eff - KW'(1);
    end

    assign q_ready    = state_reg == S_IDLE;
    assign q_pop      = q_valid && q_ready;
    assign clear_done = state_reg != S_CLEAR;
    assign out_free   = !out_valid_reg || out_ready;
    assign empty_row  = {MAX_KEEP{tkmp_pkg::EMPTY_ENTRY}};

    tkmp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CHANNELS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (q_pop),
        .raddr (AW'(q_item.channel)),
        .rdata (ram_rdata)
    );

    // insertion: new sample goes before the first entry it ties or beats
    always_comb
    begin
        base_row = cur_reg.clear ? empty_row : row_t'(ram_rdata);
        found    = 1'b0;
        for (int j = 0; j < MAX_KEEP; j++)
        begin
            ge[j] = cur_reg.insert && (j < int'(keep_eff))
                    && ($signed(cur_reg.value) >= $signed(base_row[j].value));
            new_row[j] = base_row[j];
            if (!found && ge[j])
            begin
                new_row[j].value    = cur_reg.value;
                new_row[j].position = cur_reg.position;
            end
            else if (found && (j > 0) && (j < int'(keep_eff)))
            begin
                new_row[j] = base_row[(j > 0) ? j - 1 : 0];
            end
            found = found || ge[j];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_next       = cur_reg;
        row_next       = row_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'(cur_reg.channel);
        ram_wdata      = new_row;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = empty_row;
                if (clr_cnt_reg == AW'(CHANNELS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (q_pop)
                begin
                    cur_next   = q_item;
                    state_next = S_MODIFY;
                end
            end
            S_MODIFY:
            begin
                ram_we = 1'b1;
                if (cur_reg.emit)
                begin
                    row_next      = new_row;
                    emit_idx_next = '0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_word_next.value    = row_reg[emit_idx_reg].value;
                    out_word_next.position = row_reg[emit_idx_reg].position;
                    out_word_next.rank     = tkmp_pkg::RANK_W'(emit_idx_reg);
                    out_word_next.channel  = cur_reg.channel;
                    out_word_next.last     = KW'(emit_idx_reg) == keep_last;
                    if (KW'(emit_idx_reg) == keep_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + IW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            cur_reg       <= '0;
            row_reg       <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cur_reg       <= cur_next;
            row_reg       <= row_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // a popped sample is modified in the very next cycle
    a_pop_to_modify: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == S_MODIFY)
        else $error("popped sample not followed by row update");

    // the row update only ever follows a pop
    a_modify_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MODIFY) |-> $past(q_pop))
        else $error("row update without a popped sample");

    // emission never disturbs the row memory
    a_emit_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> !ram_we)
        else $error("row memory written during emission");

    // the word flagged last closes the emission
    a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free && out_word_next.last) |=> state_reg == S_IDLE)
        else $error("emission continues past the last rank");

endmodule

`default_nettype wire

>>> hw/rtl/per_channel_top_k_max_pool.sv
// ----------------------------------------------------------------------------
// per_channel_top_k_max_pool
// keeps the keep_count largest samples per channel and emits them ranked
// ----------------------------------------------------------------------------
// Each input word is one signed q16.16 sample with its channel and position.
// For every channel a row of MAX_KEEP entries is held in one ram word; a
// sample costs one read and one write of that row, and the row update takes
// no new sample until the last one is written back. A word with tlast set
// emits the channel's list after its own insertion: keep_count result words,
// rank 0 (largest) first, one per cycle while the output is taken. A
// two-word queue sits between the input side and the row update, and
// the result register lets the next sample be taken while a result
// waits. After reset the row ram is cleared one row per cycle, during
// which s_axis_tready stays low;
// configuration writes are taken throughout. keep_count of zero acts as one
// and values above MAX_KEEP act as MAX_KEEP. Samples on a channel at or
// above CHANNELS are taken and dropped; a position at or above
// POOL_POSITIONS skips the insertion but still clears and emits. Write
// keep_count only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module per_channel_top_k_max_pool #(
    parameter int MAX_KEEP       = 8,
    parameter int CHANNELS       = 64,
    parameter int POOL_POSITIONS = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // keep_count register
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,

    // sample input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // sample_value[31:0], channel[37:32],
                                             // position[49:38], zero fill
    input  wire logic        s_axis_tuser,   // first_of_object
    input  wire logic        s_axis_tlast,   // last_of_object

    // ranked result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // kept_value[31:0], kept_position[44:32],
                                             // rank[47:45], out_channel[53:48], zero fill
    output logic             m_axis_tlast    // last_rank
);

    logic [tkmp_pkg::KEEP_W-1:0] keep_count_reg, keep_count_next;

    logic                q_valid;
    logic                q_ready;
    tkmp_pkg::item_t     q_item;
    logic                clear_done;
    tkmp_pkg::out_word_t out_word;

    // configuration register, resets to one kept entry
    assign keep_count_next = cfg_we ? cfg_wdata : keep_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= tkmp_pkg::KEEP_W'(1);
        end
        else
        begin
            keep_count_reg <= keep_count_next;
        end
    end

    // front end: classify and queue samples
    tkmp_front #(
        .CHANNELS       (CHANNELS),
        .POOL_POSITIONS (POOL_POSITIONS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .enable          (clear_done),
        .s_valid         (s_axis_tvalid),
        .s_ready         (s_axis_tready),
        .sample_value    (s_axis_tdata[31:0]),
        .channel         (s_axis_tdata[37:32]),
        .position        (s_axis_tdata[49:38]),
        .first_of_object (s_axis_tuser),
        .last_of_object  (s_axis_tlast),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item)
    );

    // back end: row update in ram and ranked emission
    tkmp_back #(
        .MAX_KEEP (MAX_KEEP),
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .keep_count (keep_count_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .clear_done (clear_done),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_word   (out_word)
    );

    // pack the result word, first field lowest
    assign m_axis_tdata = {2'b00, out_word.channel, out_word.rank,
                           out_word.position, out_word.value};
    assign m_axis_tlast = out_word.last;

endmodule

`default_nettype wire
